[rtl/core/srdz_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srdz_pkg;

  localparam int RAW_W             = 16;
  localparam int DZ_W              = 15;
  localparam int ABS_W             = RAW_W + 1;
  localparam int SQ_W              = 48;
  localparam int MAG_W             = 24;
  localparam int SQ_STAGES         = MAG_W;
  localparam int M2_W              = 32;
  localparam int OUT_FRAC_BITS_DEF = 15;
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd7849;
  localparam logic [DZ_W-1:0] RAW_MAX  = 15'd32767;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
  } in_item_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] out_x;
    logic signed [RAW_W-1:0] out_y;
    logic                    in_dead_zone;
  } out_item_t;

  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic [ABS_W-1:0] abs_x;
    logic [ABS_W-1:0] abs_y;
    logic             dead;
  } side_t;

endpackage

`default_nettype wire

[rtl/core/stick_radial_dead_zone.sv]
`timescale 1ns / 1ps
`default_nettype none

// Radial dead zone with linear rescale for one analog stick sample.
// Input channel: in_valid / in_stall carry an item with raw_x and raw_y.
// Output channel: out_valid / out_stall carry an item with out_x, out_y
// and the in_dead_zone flag; every input item yields exactly one result.
// The dead zone radius is written through cfg_wr_en / cfg_wr_data and should
// only change while no items are in flight.
// One item can enter every cycle while the receiver does not stall a held
// result. The depth comes from the bit-per-stage square root (24 stages) and
// the bit-per-stage dividers (OUT_FRAC_BITS + 2 stages).
// A synchronous active-low reset empties the pipeline and restores the
// default radius of 7849. When the receiver stalls a valid result, the whole
// pipeline freezes and in_stall rises in the same cycle, so nothing is lost
// or repeated; bubbles are not squeezed out.
module stick_radial_dead_zone
  import srdz_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [DZ_W-1:0]    cfg_wr_data
);

  // Full scale, quotient width and the widths of the divider operands.
  localparam int P     = OUT_FRAC_BITS;
  localparam logic [P-1:0] FS = {P{1'b1}};
  localparam int QW    = P + 2;
  localparam int PA_W  = ABS_W + P;
  localparam int NUM_W = PA_W + MAG_W;
  localparam int DEN_W = MAG_W + DZ_W;
  localparam int DD_W  = DEN_W + 1;
  localparam int RW    = P + 43;

  logic adv;
  logic out_valid_r;
  out_item_t out_r;

  // The whole pipeline moves together unless a finished result is held.
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Configuration register and its square, used for the dead zone compare.
  logic [DZ_W-1:0]   dz_r;
  logic [2*DZ_W-1:0] dz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (cfg_wr_en) begin
      dz_r <= cfg_wr_data;
    end
    dz2_r <= dz_r * dz_r;
  end

  // Stage A: absolute values, signs and the two squares.
  logic signed [ABS_W-1:0] xe, ye;
  logic [ABS_W-1:0]        absx, absy;
  logic                    a_vld_r;
  side_t                   a_side_r;
  logic [M2_W-2:0]         a_sqx_r, a_sqy_r;

  assign xe   = {in_item.raw_x[RAW_W-1], in_item.raw_x};
  assign ye   = {in_item.raw_y[RAW_W-1], in_item.raw_y};
  assign absx = xe[ABS_W-1] ? ABS_W'(-xe) : ABS_W'(xe);
  assign absy = ye[ABS_W-1] ? ABS_W'(-ye) : ABS_W'(ye);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
    if (adv) begin
      a_side_r.neg_x <= xe[ABS_W-1];
      a_side_r.neg_y <= ye[ABS_W-1];
      a_side_r.abs_x <= absx;
      a_side_r.abs_y <= absy;
      a_side_r.dead  <= 1'b0;
      a_sqx_r        <= (M2_W-1)'(absx * absx);
      a_sqy_r        <= (M2_W-1)'(absy * absy);
    end
  end

  // Stage B feeds the square root chain: sum of squares and dead zone test.
  logic [M2_W-1:0]  m2;
  side_t            b_side;
  logic             sq_vld_r  [0:SQ_STAGES];
  side_t            sq_side_r [0:SQ_STAGES];
  logic [SQ_W-1:0]  sq_rem_r  [0:SQ_STAGES];
  logic [MAG_W-1:0] sq_root_r [0:SQ_STAGES];

  assign m2 = M2_W'(a_sqx_r) + M2_W'(a_sqy_r);

  always_comb begin
    b_side      = a_side_r;
    b_side.dead = (m2 <= M2_W'(dz2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= a_vld_r;
    end
    if (adv) begin
      sq_side_r[0] <= b_side;
      sq_rem_r[0]  <= {m2, 16'b0};
      sq_root_r[0] <= '0;
    end
  end

  // Square root of m2 * 2^16, one result bit per stage, most significant
  // bit first.
  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
    localparam int K = SQ_STAGES - 1 - i;
    logic [SQ_W-1:0] trial;

    assign trial = (SQ_W'(sq_root_r[i]) << (K + 1)) + (SQ_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[i+1] <= sq_vld_r[i];
      end
      if (adv) begin
        sq_side_r[i+1] <= sq_side_r[i];
        if (sq_rem_r[i] >= trial) begin
          sq_rem_r[i+1]  <= sq_rem_r[i] - trial;
          sq_root_r[i+1] <= sq_root_r[i] | (MAG_W'(1) << K);
        end else begin
          sq_rem_r[i+1]  <= sq_rem_r[i];
          sq_root_r[i+1] <= sq_root_r[i];
        end
      end
    end
  end

  // Stage C: distance past the dead zone and whether the scale clamps to 1.
  logic [MAG_W-1:0] mag8, diff, span;
  logic [DZ_W-1:0]  ms;
  logic             c_vld_r, c_full_r;
  side_t            c_side_r;
  logic [MAG_W-1:0] c_diff_r, c_mag_r;
  logic [DZ_W-1:0]  c_ms_r;
  logic [PA_W-1:0]  c_pax_r, c_pay_r;

  assign mag8 = sq_root_r[SQ_STAGES];
  assign ms   = RAW_MAX - dz_r;
  assign diff = mag8 - {1'b0, dz_r, 8'b0};
  assign span = {1'b0, ms, 8'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= sq_vld_r[SQ_STAGES];
    end
    if (adv) begin
      c_side_r <= sq_side_r[SQ_STAGES];
      c_full_r <= (diff >= span);
      c_diff_r <= diff;
      c_mag_r  <= mag8;
      c_ms_r   <= ms;
      c_pax_r  <= PA_W'(sq_side_r[SQ_STAGES].abs_x * FS);
      c_pay_r  <= PA_W'(sq_side_r[SQ_STAGES].abs_y * FS);
    end
  end

  // Stage D: numerators and the shared denominator.
  logic             d_vld_r;
  side_t            d_side_r;
  logic [NUM_W-1:0] d_numx_r, d_numy_r;
  logic [DEN_W-1:0] d_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
    if (adv) begin
      d_side_r <= c_side_r;
      if (c_full_r) begin
        d_numx_r <= NUM_W'(c_pax_r) << 8;
        d_numy_r <= NUM_W'(c_pay_r) << 8;
        d_den_r  <= DEN_W'(c_mag_r);
      end else begin
        d_numx_r <= NUM_W'(c_pax_r * c_diff_r);
        d_numy_r <= NUM_W'(c_pay_r * c_diff_r);
        d_den_r  <= DEN_W'(c_mag_r * c_ms_r);
      end
    end
  end

  // Stage E and the divider chains: round half up as (2n + d) / (2d).
  logic            dv_vld_r  [0:QW];
  side_t           dv_side_r [0:QW];
  logic [DD_W-1:0] dv_d_r    [0:QW];
  logic [RW-1:0]   dv_rem_r  [0:1][0:QW];
  logic [QW-1:0]   dv_q_r    [0:1][0:QW];
  logic            dv_sat_r  [0:1][0:QW];
  logic [RW-1:0]   nx, ny, dsh;
  logic [DD_W-1:0] dd;

  assign dd  = {d_den_r, 1'b0};
  assign nx  = (RW'(d_numx_r) << 1) + RW'(d_den_r);
  assign ny  = (RW'(d_numy_r) << 1) + RW'(d_den_r);
  assign dsh = RW'(dd) << QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= d_vld_r;
    end
    if (adv) begin
      dv_side_r[0]   <= d_side_r;
      dv_d_r[0]      <= dd;
      dv_rem_r[0][0] <= nx;
      dv_rem_r[1][0] <= ny;
      dv_q_r[0][0]   <= '0;
      dv_q_r[1][0]   <= '0;
      dv_sat_r[0][0] <= (nx >= dsh);
      dv_sat_r[1][0] <= (ny >= dsh);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int KB = QW - 1 - j;
    logic [RW-1:0] dshift;

    assign dshift = RW'(dv_d_r[j]) << KB;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
      if (adv) begin
        dv_side_r[j+1] <= dv_side_r[j];
        dv_d_r[j+1]    <= dv_d_r[j];
      end
    end

    for (genvar a = 0; a < 2; a++) begin : g_axis
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_sat_r[a][j+1] <= dv_sat_r[a][j];
          if (dv_rem_r[a][j] >= dshift) begin
            dv_rem_r[a][j+1] <= dv_rem_r[a][j] - dshift;
            dv_q_r[a][j+1]   <= dv_q_r[a][j] | (QW'(1) << KB);
          end else begin
            dv_rem_r[a][j+1] <= dv_rem_r[a][j];
            dv_q_r[a][j+1]   <= dv_q_r[a][j];
          end
        end
      end
    end
  end

  // Output stage: saturate at full scale, apply the sign, zero the dead zone.
  logic [P-1:0]     magx, magy;
  logic [RAW_W-1:0] ux, uy;
  side_t            fs;

  assign fs   = dv_side_r[QW];
  assign magx = (dv_sat_r[0][QW] || dv_q_r[0][QW] > QW'(FS)) ? FS : P'(dv_q_r[0][QW]);
  assign magy = (dv_sat_r[1][QW] || dv_q_r[1][QW] > QW'(FS)) ? FS : P'(dv_q_r[1][QW]);
  assign ux   = fs.neg_x ? RAW_W'(-RAW_W'(magx)) : RAW_W'(magx);
  assign uy   = fs.neg_y ? RAW_W'(-RAW_W'(magy)) : RAW_W'(magy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld_r[QW];
    end
    if (adv) begin
      out_r.in_dead_zone <= fs.dead;
      out_r.out_x        <= fs.dead ? '0 : ux;
      out_r.out_y        <= fs.dead ? '0 : uy;
    end
  end

endmodule

`default_nettype wire

[test/stick_radial_dead_zone_tb.sv]
`timescale 1ns / 1ps

module stick_radial_dead_zone_tb;
  import srdz_pkg::*;

  localparam int LATENCY = 47;
  localparam int FS = 32767;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [DZ_W-1:0] cfg_wr_data = '0;

  stick_radial_dead_zone dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Samples waiting to be driven, and the shaped results still owed by the block.
  in_item_t pending_samples[$];
  out_item_t owed_results[$];
  // The predictor's own copy of the dead zone radius.
  logic [DZ_W-1:0] radius = DZ_RESET;
  int errors = 0;
  int sent = 0;
  int received = 0;
  int dead_seen = 0;
  // Percent chances that the sender idles and the receiver stalls in a cycle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Set at a rising edge when the driven sample was taken by the block.
  logic in_taken = 1'b0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Integer square root of a 64-bit value, one result bit per pass.
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // One axis times the rescaled magnitude, rounded half up and saturated.
  function automatic logic signed [15:0] shape_axis(input longint a, input longint unsigned mag8,
      input longint unsigned diff, input longint unsigned span);
    longint unsigned absa, num, den, q;
    absa = (a < 0) ? -a : a;
    if (diff >= span) begin
      num = absa * FS * 256;
      den = mag8;
    end else begin
      num = absa * FS * diff;
      den = mag8 * (32767 - radius);
    end
    q = (2 * num + den) / (2 * den);
    if (q > FS) q = FS;
    return (a < 0) ? -q[15:0] : q[15:0];
  endfunction

  function automatic out_item_t shape_sample(input in_item_t s);
    out_item_t r;
    longint x, y;
    longint unsigned m2, dz, mag8, diff, span;
    x = s.raw_x;
    y = s.raw_y;
    dz = radius;
    m2 = x * x + y * y;
    r = '0;
    if (m2 <= dz * dz) begin
      // Inside the dead zone both axes collapse to zero.
      r.in_dead_zone = 1'b1;
    end else begin
      mag8 = root64(m2 << 16);
      diff = mag8 - dz * 256;
      span = (32767 - dz) * 256;
      r.out_x = shape_axis(x, mag8, diff, span);
      r.out_y = shape_axis(y, mag8, diff, span);
    end
    return r;
  endfunction

  // Driver: a new sample goes out at the falling edge once the previous one
  // was taken at the rising edge before. The payload holds while it waits.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_samples[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predictions are queued when a sample is accepted and checked
  // against each accepted result in order.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_samples.pop_front();
        owed_results.push_back(shape_sample(in_item));
        sent++;
      end
      if (out_valid && !out_stall) begin
        received++;
        if (owed_results.size() == 0) begin
          report_mismatch("result with no sample outstanding");
        end else begin
          out_item_t e;
          e = owed_results.pop_front();
          if (out_item.out_x !== e.out_x)
            report_mismatch($sformatf("out_x %0d expected %0d", out_item.out_x, e.out_x));
          if (out_item.out_y !== e.out_y)
            report_mismatch($sformatf("out_y %0d expected %0d", out_item.out_y, e.out_y));
          if (out_item.in_dead_zone !== e.in_dead_zone)
            report_mismatch($sformatf("in_dead_zone %0b expected %0b",
                                      out_item.in_dead_zone, e.in_dead_zone));
          if (e.in_dead_zone) dead_seen++;
        end
      end
    end
  end

  function automatic in_item_t make_sample(input int x, input int y);
    in_item_t s;
    s.raw_x = x[15:0];
    s.raw_y = y[15:0];
    return s;
  endfunction

  // Random samples: mostly magnitudes near the radius and across the
  // rescale ramp, plus fully random raw words.
  task automatic queue_random(input int count);
    int mode, r, x, y;
    real ang;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(3);
      if (mode == 0) begin
        x = $urandom;
        y = $urandom;
        pending_samples.push_back(make_sample(x, y));
      end else begin
        if (mode == 1) r = int'(radius) + $urandom_range(8) - 4;
        else r = $urandom_range(32800);
        ang = $urandom_range(6283) / 1000.0;
        x = $rtoi(r * $cos(ang));
        y = $rtoi(r * $sin(ang));
        if (x > 32767) x = 32767;
        if (y > 32767) y = 32767;
        if (x < -32768) x = -32768;
        if (y < -32768) y = -32768;
        pending_samples.push_back(make_sample(x, y));
      end
    end
  endtask

  // Waits until every owed result is in and the pipeline has drained.
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Register writes happen only while the block is empty.
  task automatic write_radius(input logic [DZ_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    radius = v;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed samples at the reset radius: the origin, axis extremes, the
    // corners, points right at the radius, and a magnitude past full scale.
    pending_samples.push_back(make_sample(0, 0));
    pending_samples.push_back(make_sample(32767, 0));
    pending_samples.push_back(make_sample(-32768, 0));
    pending_samples.push_back(make_sample(0, 32767));
    pending_samples.push_back(make_sample(0, -32768));
    pending_samples.push_back(make_sample(-32768, -32768));
    pending_samples.push_back(make_sample(32767, 32767));
    pending_samples.push_back(make_sample(32767, -32768));
    pending_samples.push_back(make_sample(7849, 0));
    pending_samples.push_back(make_sample(7850, 0));
    pending_samples.push_back(make_sample(0, -7849));
    pending_samples.push_back(make_sample(-7850, 1));
    pending_samples.push_back(make_sample(20000, -15000));
    pending_samples.push_back(make_sample(-1, 1));
    pending_samples.push_back(make_sample(23170, 23170));
    drain();

    // Radius extremes: zero, where every nonzero sample rescales, and 32766,
    // one below RAW_MAX, where samples outside rescale over a span of one.
    write_radius(15'd0);
    pending_samples.push_back(make_sample(0, 0));
    pending_samples.push_back(make_sample(1, 0));
    pending_samples.push_back(make_sample(-1, -1));
    pending_samples.push_back(make_sample(16384, -3));
    queue_random(40);
    drain();
    write_radius(15'd32766);
    pending_samples.push_back(make_sample(32766, 0));
    pending_samples.push_back(make_sample(32767, 0));
    pending_samples.push_back(make_sample(-32768, 0));
    pending_samples.push_back(make_sample(30000, 20000));
    queue_random(40);
    drain();

    // Random phases across radii and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_radius(ph == 7 ? DZ_RESET : 15'($urandom_range(32766)));
      queue_random(55);
      // The sender holds back until the block has emptied.
      wait (pending_samples.size() == 0 && !in_valid && owed_results.size() == 0);
      queue_random(55);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (LATENCY) @(posedge clk);

    $display("Covered %0d samples and %0d results, %0d inside the dead zone,",
             sent, received, dead_seen);
    $display("over radii from zero to the top value with sender and receiver idling.");
    if (errors == 0) begin
      $display("stick_radial_dead_zone_tb: clean");
    end else begin
      $display("stick_radial_dead_zone_tb: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("stick_radial_dead_zone_tb: errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/srdz_pkg.sv
rtl/core/stick_radial_dead_zone.sv
test/stick_radial_dead_zone_tb.sv
